FILE: rtl/core/scpt_pkg.sv
// Shared types, register offsets and the prescaler table of the prescaled timer core.
package scpt_pkg;

    localparam int TIMER_COUNT_DEF = 6;
    localparam int COUNT_BITS_DEF  = 32;
    localparam int DATA_BITS       = 32;
    localparam int ADDR_BITS       = 7;
    localparam int PRESCALE_BITS   = 6;
    localparam int DIVISOR_BITS    = 7;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef logic [3:0] t_div_index;

    // Register offsets inside one timer's 16-byte group.
    localparam logic [3:0] REG_CON = 4'h0;
    localparam logic [3:0] REG_CLK = 4'h4;
    localparam logic [3:0] REG_CNT = 4'h8;

    // Prescaler index that has no divisor: the timer holds.
    localparam t_div_index HALT_INDEX = 4'hF;

    function automatic logic [DIVISOR_BITS-1:0] divisor_of(input t_div_index idx);
        logic [DIVISOR_BITS-1:0] div;
        case (idx)
            4'd0:    div = 7'd1;
            4'd1:    div = 7'd2;
            4'd2:    div = 7'd3;
            4'd3:    div = 7'd4;
            4'd4:    div = 7'd5;
            4'd5:    div = 7'd6;
            4'd6:    div = 7'd8;
            4'd7:    div = 7'd9;
            4'd8:    div = 7'd10;
            4'd9:    div = 7'd11;
            4'd10:   div = 7'd12;
            4'd11:   div = 7'd13;
            4'd12:   div = 7'd16;
            4'd13:   div = 7'd32;
            4'd14:   div = 7'd64;
            default: div = 7'd0;
        endcase
        return div;
    endfunction

endpackage

FILE: rtl/core/scpt_req_if.sv
// Request channel: register access or clock tick beats into the timer core.
interface scpt_req_if;
    import scpt_pkg::*;

    logic                  valid;
    logic                  ready;
    t_action               action;
    logic [ADDR_BITS-1:0]  address;
    logic [DATA_BITS-1:0]  write_data;
    logic                  sys_strobe;
    logic                  rtc_strobe;

    modport source (output valid, action, address, write_data, sys_strobe, rtc_strobe,
                    input ready);
    modport sink   (input valid, action, address, write_data, sys_strobe, rtc_strobe,
                    output ready);
endinterface

FILE: rtl/core/scpt_rsp_if.sv
// Response channel: one read data beat per request beat.
interface scpt_rsp_if;
    import scpt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [DATA_BITS-1:0]  read_data;

    modport source (output valid, read_data, input ready);
    modport sink   (input valid, read_data, output ready);
endinterface

FILE: rtl/core/six_channel_prescaled_timer_core.sv
// Top level of the six-channel prescaled up-counting timer core.
//
// Up to TIMER_COUNT up-counters of COUNT_BITS bits sit behind a 128-byte
// register window; timer n owns the group at byte offset 0x10*(n+1) with CON
// (+0: bit0 enable, bit1 write-one-to-clear the count; reads return bit0),
// CLK (+4: bits3:0 prescaler index into 1,2,3,4,5,6,8,9,10,11,12,13,16,32,64,
// index 15 holds the timer; bit4 picks the RTC strobe over the system strobe;
// a write restarts the prescaler) and CNT (+8, read only). Anything else reads
// zero and drops writes. Every request beat is a read, a write, a tick or an
// idle beat (ACT_NONE), and each gives exactly one response beat, zero unless it was a register read.
// The core takes one request beat per clock, back to back, as long as the
// response side keeps taking beats; with a response held downstream it takes
// one more beat into the input register and then stalls its request side.
// The input register and the response register bracket the single pass
// through the timer state.
// A tick updates every timer in that same pass.
module six_channel_prescaled_timer_core #(
    parameter int TIMER_COUNT = scpt_pkg::TIMER_COUNT_DEF,
    parameter int COUNT_BITS  = scpt_pkg::COUNT_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    scpt_req_if.sink   i_req,
    scpt_rsp_if.source o_rsp
);
    import scpt_pkg::*;

    // ---------------------------------------------------------------------
    // Input register: holds one request beat until the timer pass takes it.
    // ---------------------------------------------------------------------
    logic                  r_in_valid;
    t_action               r_action;
    logic [ADDR_BITS-1:0]  r_address;
    logic [DATA_BITS-1:0]  r_write_data;
    logic                  r_sys_strobe;
    logic                  r_rtc_strobe;

    // Response register.
    logic                  r_out_valid;
    logic [DATA_BITS-1:0]  r_out_data;
    logic [DATA_BITS-1:0]  n_out_data;

    // Per-timer state.
    logic                     r_enable   [TIMER_COUNT];
    t_div_index               r_div      [TIMER_COUNT];
    logic                     r_source   [TIMER_COUNT];
    logic [PRESCALE_BITS-1:0] r_prescale [TIMER_COUNT];
    logic [COUNT_BITS-1:0]    r_count    [TIMER_COUNT];

    logic                     n_enable   [TIMER_COUNT];
    t_div_index               n_div      [TIMER_COUNT];
    logic                     n_source   [TIMER_COUNT];
    logic [PRESCALE_BITS-1:0] n_prescale [TIMER_COUNT];
    logic [COUNT_BITS-1:0]    n_count    [TIMER_COUNT];

    logic       w_advance;
    logic [2:0] w_group;
    logic [3:0] w_offset;

    // Advance the held beat when the response register is free or draining.
    assign w_advance   = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_advance;

    assign w_group  = r_address[ADDR_BITS-1:4];
    assign w_offset = r_address[3:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    // Payload needs no reset; load only on an accepted beat.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_action     <= i_req.action;
            r_address    <= i_req.address;
            r_write_data <= i_req.write_data;
            r_sys_strobe <= i_req.sys_strobe;
            r_rtc_strobe <= i_req.rtc_strobe;
        end
    end

    // ---------------------------------------------------------------------
    // Single pass: decode, read mux and next state for every timer.
    // Group 0 is the empty header slot; timer k answers on group k+1.
    // ---------------------------------------------------------------------
    always_comb begin
        logic                    hit;
        logic                    strobe;
        logic [DIVISOR_BITS-1:0] pc_next;

        n_out_data = '0;
        for (int k = 0; k < TIMER_COUNT; k++) begin
            hit     = (w_group == 3'(k + 1));
            strobe  = r_source[k] ? r_rtc_strobe : r_sys_strobe;
            pc_next = {1'b0, r_prescale[k]} + DIVISOR_BITS'(1);

            n_enable[k]   = r_enable[k];
            n_div[k]      = r_div[k];
            n_source[k]   = r_source[k];
            n_prescale[k] = r_prescale[k];
            n_count[k]    = r_count[k];

            case (r_action)
                ACT_READ: begin
                    if (hit) begin
                        case (w_offset)
                            REG_CON: n_out_data = n_out_data
                                                | DATA_BITS'(r_enable[k]);
                            REG_CLK: n_out_data = n_out_data
                                                | DATA_BITS'({r_source[k], r_div[k]});
                            REG_CNT: n_out_data = n_out_data
                                                | DATA_BITS'(r_count[k]);
                            default: ;
                        endcase
                    end
                end
                ACT_WRITE: begin
                    if (hit) begin
                        case (w_offset)
                            REG_CON: begin
                                if (r_write_data[1]) begin
                                    n_count[k] = '0;
                                end
                                n_enable[k] = r_write_data[0];
                            end
                            REG_CLK: begin
                                n_div[k]      = r_write_data[3:0];
                                n_source[k]   = r_write_data[4];
                                n_prescale[k] = '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ACT_TICK: begin
                    if (r_enable[k] && strobe && (r_div[k] != HALT_INDEX)) begin
                        if (pc_next >= divisor_of(r_div[k])) begin
                            n_prescale[k] = '0;
                            n_count[k]    = r_count[k] + COUNT_BITS'(1);
                        end else begin
                            n_prescale[k] = pc_next[PRESCALE_BITS-1:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TIMER_COUNT; k++) begin
                r_enable[k]   <= 1'b0;
                r_div[k]      <= '0;
                r_source[k]   <= 1'b1;
                r_prescale[k] <= '0;
                r_count[k]    <= '0;
            end
        end else if (w_advance) begin
            for (int k = 0; k < TIMER_COUNT; k++) begin
                r_enable[k]   <= n_enable[k];
                r_div[k]      <= n_div[k];
                r_source[k]   <= n_source[k];
                r_prescale[k] <= n_prescale[k];
                r_count[k]    <= n_count[k];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Response register.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_data = r_out_data;

`ifndef SYNTHESIS
    // Backpressure only when both stages are full.
    a_ready_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (r_in_valid && r_out_valid))
        else $error("request stalled with a free stage");

    // The prescaler never reaches the divisor of a counting index.
    a_prescale_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_div[0] != HALT_INDEX) |->
            ({1'b0, r_prescale[0]} < divisor_of(r_div[0])))
        else $error("prescaler beyond divisor");

    // A held timer keeps its count through a tick.
    a_halt_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_action == ACT_TICK) && (r_div[0] == HALT_INDEX)) |=>
            (r_count[0] == $past(r_count[0])))
        else $error("held timer counted");

    // A disabled timer only changes its count through a register write.
    a_disabled_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_action != ACT_WRITE) && !r_enable[0]) |=>
            (r_count[0] == $past(r_count[0])))
        else $error("disabled timer counted");
`endif

endmodule
